// File: src/mcrt_pkg.sv
// Shared types and constants for the Mandelbrot corner refine block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package mcrt_pkg;

  localparam int IN_W    = 32;
  localparam int LEVEL_W = 4;
  localparam int ITER_W  = 10;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_MAXIT  = 2'd1;
  localparam logic [1:0] REG_FORCED = 2'd2;

  localparam logic [LEVEL_W-1:0] TARGET_RST = 4'd6;
  localparam logic [ITER_W-1:0]  MAXIT_RST  = 10'd100;
  localparam logic [LEVEL_W-1:0] FORCED_RST = 4'd2;

  localparam logic [1:0] CORNER_LAST = 2'd3;
  localparam logic [3:0] MASK_ALL    = 4'hF;

  typedef enum logic [1:0] {
    FIN_KEEP,
    FIN_SPLIT,
    FIN_MASK
  } fin_sel_e;

  typedef struct packed {
    logic signed [IN_W-1:0] x_low;
    logic signed [IN_W-1:0] x_high;
    logic signed [IN_W-1:0] y_low;
    logic signed [IN_W-1:0] y_high;
    logic [LEVEL_W-1:0]     tree_level;
  } mcrt_req_t;

  typedef struct packed {
    logic       refine;
    logic [3:0] corner_mask;
  } mcrt_res_t;

  typedef struct packed {
    logic     capture;
    logic     init;
    logic     test;
    logic     mul;
    logic     upd;
    logic     corner_done;
    logic     in_set;
    logic     fin;
    fin_sel_e fin_sel;
  } mcrt_cmd_t;

  typedef struct packed {
    logic lvl_target;
    logic lvl_forced;
    logic cnt_max;
    logic out_range;
    logic escape;
    logic last_corner;
  } mcrt_sts_t;

endpackage

// File: src/mcrt_ctrl.sv
// Sequencer for the corner refine block: level decision, per-corner escape loop.
// Depends on mcrt_pkg; drives mcrt_dpath through mcrt_cmd_t.
`timescale 1ns / 1ps

module mcrt_ctrl import mcrt_pkg::*; #(
  parameter int MUL_CYCLES = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output logic      done_o,
  input  mcrt_sts_t sts_i,
  output mcrt_cmd_t cmd_o
);

  localparam int MCW = (MUL_CYCLES > 1) ? $clog2(MUL_CYCLES) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_TEST   = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;
  localparam logic [2:0] S_FIN    = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [MCW-1:0] mul_cnt_q, mul_cnt_d;
  logic           done_q, done_d;
  logic           mul_last;

  assign mul_last = (mul_cnt_q == MCW'(MUL_CYCLES - 1));

  always_comb begin
    state_d   = state_q;
    mul_cnt_d = mul_cnt_q;
    done_d    = 1'b0;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts_i.lvl_target) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_KEEP;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else if (sts_i.lvl_forced) begin
          cmd_o.fin     = 1'b1;
          cmd_o.fin_sel = FIN_SPLIT;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.init = 1'b1;
          state_d    = S_TEST;
        end
      end
      S_TEST: begin
        // limit reached wins over the magnitude check
        if (sts_i.cnt_max || sts_i.out_range) begin
          cmd_o.corner_done = 1'b1;
          cmd_o.in_set      = sts_i.cnt_max;
          state_d           = sts_i.last_corner ? S_FIN : S_TEST;
        end else begin
          cmd_o.test = 1'b1;
          mul_cnt_d  = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (mul_last) begin
          state_d = S_UPD;
        end else begin
          mul_cnt_d = mul_cnt_q + MCW'(1);
        end
      end
      S_UPD: begin
        if (sts_i.escape) begin
          cmd_o.corner_done = 1'b1;
          cmd_o.in_set      = 1'b0;
          state_d           = sts_i.last_corner ? S_FIN : S_TEST;
        end else begin
          cmd_o.upd = 1'b1;
          state_d   = S_TEST;
        end
      end
      S_FIN: begin
        cmd_o.fin     = 1'b1;
        cmd_o.fin_sel = FIN_MASK;
        done_d        = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mul_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      mul_cnt_q <= mul_cnt_d;
      done_q    <= done_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held longer than one cycle");

  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(state_q) == S_DECIDE || $past(state_q) == S_FIN))
    else $error("result strobe from unexpected state");

  a_upd_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> ($past(state_q) == S_MUL))
    else $error("update entered without multiply");

  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (int'(mul_cnt_q) < MUL_CYCLES))
    else $error("multiply step counter out of range");
`endif

endmodule

// File: src/mcrt_dpath.sv
// Datapath: captured rectangle, z registers, chunked squaring unit, corner mask.
// Depends on mcrt_pkg; sequenced by mcrt_ctrl.
`timescale 1ns / 1ps

module mcrt_dpath import mcrt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int MUL_CYCLES  = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcrt_req_t          req_i,
  input  logic [LEVEL_W-1:0] target_i,
  input  logic [ITER_W-1:0]  max_iter_i,
  input  logic [LEVEL_W-1:0] forced_i,
  input  mcrt_cmd_t          cmd_i,
  output mcrt_sts_t          sts_o,
  output mcrt_res_t          res_o
);

  // z width: |2*zr*zi| < 8.0 and |zr^2 - zi^2| < 4.0, plus c
  localparam int ZW = ((FRAC_BITS + 3 > COORD_WIDTH - 1) ? FRAC_BITS + 3
                                                         : COORD_WIDTH - 1) + 2;
  localparam int MW = FRAC_BITS + 1;                    // |z| < 2.0 operand
  localparam int CH = (MW + MUL_CYCLES - 1) / MUL_CYCLES;
  localparam int BW = CH * MUL_CYCLES;
  localparam int AW = BW + MW;
  localparam int SW = FRAC_BITS + 2;                    // square after shift

  mcrt_req_t              req_q;
  mcrt_res_t              res_q;
  logic [1:0]             corner_q;
  logic [3:0]             mask_q;
  logic [ITER_W-1:0]      cnt_q;
  logic signed [ZW-1:0]   zr_q, zi_q;
  logic [MW-1:0]          ar_q, ai_q;
  logic [BW-1:0]          br_q, bi_q;
  logic                   neg_q;
  logic [AW-1:0]          acc_rr_q, acc_ii_q, acc_ri_q;

  logic [COORD_WIDTH+IN_W-1:0] xl_ext, xh_ext, yl_ext, yh_ext;
  logic signed [COORD_WIDTH-1:0] xl_c, xh_c, yl_c, yh_c;
  logic signed [ZW-1:0]   cr_z, ci_z;
  logic [ZW-1:0]          zr_mag, zi_mag;
  logic [MW+CH-1:0]       p_rr, p_ii, p_ri;
  logic [SW-1:0]          sq_r, sq_i, prod;
  logic [SW:0]            sq_sum, twop;
  logic signed [ZW-1:0]   twop_s, zr_new, zi_new;

  // bits above COORD_WIDTH are dropped, then sign-extended from COORD_WIDTH
  assign xl_ext = {{COORD_WIDTH{1'b0}}, req_q.x_low};
  assign xh_ext = {{COORD_WIDTH{1'b0}}, req_q.x_high};
  assign yl_ext = {{COORD_WIDTH{1'b0}}, req_q.y_low};
  assign yh_ext = {{COORD_WIDTH{1'b0}}, req_q.y_high};
  assign xl_c   = xl_ext[COORD_WIDTH-1:0];
  assign xh_c   = xh_ext[COORD_WIDTH-1:0];
  assign yl_c   = yl_ext[COORD_WIDTH-1:0];
  assign yh_c   = yh_ext[COORD_WIDTH-1:0];

  // corner bit0 picks x bound, bit1 picks y bound
  assign cr_z = corner_q[0] ? ZW'(xh_c) : ZW'(xl_c);
  assign ci_z = corner_q[1] ? ZW'(yh_c) : ZW'(yl_c);

  assign zr_mag = zr_q[ZW-1] ? unsigned'(-zr_q) : unsigned'(zr_q);
  assign zi_mag = zi_q[ZW-1] ? unsigned'(-zi_q) : unsigned'(zi_q);

  // one chunk of b per cycle, top chunk first (Horner)
  assign p_rr = ar_q * br_q[BW-1 -: CH];
  assign p_ii = ai_q * bi_q[BW-1 -: CH];
  assign p_ri = ar_q * bi_q[BW-1 -: CH];

  assign sq_r   = acc_rr_q[FRAC_BITS +: SW];
  assign sq_i   = acc_ii_q[FRAC_BITS +: SW];
  assign prod   = acc_ri_q[FRAC_BITS +: SW];
  assign sq_sum = {1'b0, sq_r} + {1'b0, sq_i};
  assign twop   = {prod, 1'b0};
  assign twop_s = signed'(ZW'(twop));
  assign zi_new = (neg_q ? -twop_s : twop_s) + ci_z;
  assign zr_new = signed'(ZW'(sq_r)) - signed'(ZW'(sq_i)) + cr_z;

  assign sts_o.lvl_target  = (req_q.tree_level == target_i);
  assign sts_o.lvl_forced  = (req_q.tree_level < forced_i);
  assign sts_o.cnt_max     = (cnt_q == max_iter_i);
  assign sts_o.out_range   = (|zr_mag[ZW-1:MW]) | (|zi_mag[ZW-1:MW]);
  assign sts_o.escape      = sq_sum[SW];   // sum >= 4.0
  assign sts_o.last_corner = (corner_q == CORNER_LAST);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.init) begin
      corner_q <= 2'd0;
      mask_q   <= 4'd0;
      cnt_q    <= '0;
      zr_q     <= '0;
      zi_q     <= '0;
    end
    if (cmd_i.corner_done) begin
      mask_q[corner_q] <= cmd_i.in_set;
      corner_q         <= corner_q + 2'd1;
      cnt_q            <= '0;
      zr_q             <= '0;
      zi_q             <= '0;
    end
    if (cmd_i.test) begin
      ar_q     <= zr_mag[MW-1:0];
      ai_q     <= zi_mag[MW-1:0];
      br_q     <= BW'(zr_mag[MW-1:0]);
      bi_q     <= BW'(zi_mag[MW-1:0]);
      neg_q    <= zr_q[ZW-1] ^ zi_q[ZW-1];
      acc_rr_q <= '0;
      acc_ii_q <= '0;
      acc_ri_q <= '0;
    end
    if (cmd_i.mul) begin
      acc_rr_q <= (acc_rr_q << CH) + AW'(p_rr);
      acc_ii_q <= (acc_ii_q << CH) + AW'(p_ii);
      acc_ri_q <= (acc_ri_q << CH) + AW'(p_ri);
      br_q     <= br_q << CH;
      bi_q     <= bi_q << CH;
    end
    if (cmd_i.upd) begin
      zr_q  <= zr_new;
      zi_q  <= zi_new;
      cnt_q <= cnt_q + ITER_W'(1);
    end
    if (cmd_i.fin) begin
      case (cmd_i.fin_sel)
        FIN_SPLIT: begin
          res_q.refine      <= 1'b1;
          res_q.corner_mask <= 4'd0;
        end
        FIN_MASK: begin
          res_q.refine      <= (mask_q != 4'd0) && (mask_q != MASK_ALL);
          res_q.corner_mask <= mask_q;
        end
        default: begin
          res_q.refine      <= 1'b0;
          res_q.corner_mask <= 4'd0;
        end
      endcase
    end
  end

  // reset clears the result gate, so res_o reads zero until the first capture
  logic rst_seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rst_seen_q <= 1'b0;
    end else if (cmd_i.capture) begin
      rst_seen_q <= 1'b1;
    end
  end

  assign res_o = rst_seen_q ? res_q : '0;

endmodule

// File: src/mandelbrot_corner_refine_test.sv
// Top level: APB register file plus controller and datapath of the corner test.
// Depends on mcrt_pkg, mcrt_ctrl and mcrt_dpath.
//
//   channel   signals                          dir   accepted when
//   request   start_i, busy_o, req_i           in    start_i & !busy_o
//   result    done_o, res_o                    out   every cycle done_o is high
//   config    psel..pready, paddr, pwdata      in    psel & penable & pwrite & pready
//
// At the target level, or below the forced level, an item goes from the decide
// state straight to its result. Otherwise each corner loops over a check, the
// multiply steps on the shared squaring unit (one multiply step at FRAC_BITS <= 31)
// and an update. A corner ends on a check cycle, or on its update cycle once the
// squares reach 4.0; the four corners run in turn before the result.
// busy_o stays high until the result beat; the beat shows for one cycle only.
// Reset restores the register defaults and idles the sequencer.
`timescale 1ns / 1ps

module mandelbrot_corner_refine_test import mcrt_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  mcrt_req_t         req_i,
  output logic              done_o,
  output mcrt_res_t         res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int MW         = FRAC_BITS + 1;
  localparam int MUL_CYCLES = (MW + 31) / 32;

  logic [LEVEL_W-1:0] target_q;
  logic [ITER_W-1:0]  maxit_q;
  logic [LEVEL_W-1:0] forced_q;
  logic               wr_en;
  mcrt_cmd_t          cmd;
  mcrt_sts_t          sts;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      maxit_q  <= MAXIT_RST;
      forced_q <= FORCED_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_TARGET: target_q <= pwdata[LEVEL_W-1:0];
        REG_MAXIT:  maxit_q  <= pwdata[ITER_W-1:0];
        REG_FORCED: forced_q <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TARGET: prdata = DATA_W'(target_q);
      REG_MAXIT:  prdata = DATA_W'(maxit_q);
      REG_FORCED: prdata = DATA_W'(forced_q);
      default:    prdata = '0;
    endcase
  end

  mcrt_ctrl #(
    .MUL_CYCLES(MUL_CYCLES)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mcrt_dpath #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .MUL_CYCLES (MUL_CYCLES)
  ) u_dpath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .target_i  (target_q),
    .max_iter_i(maxit_q),
    .forced_i  (forced_q),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .res_o     (res_o)
  );

endmodule
